FILE: hdl/tva_pkg.sv
// ----------------------------------------------------------------------------
// tva_pkg
// Shared types, fixed-point constants and helper functions for the thrust
// vector to attitude pipeline.
// ----------------------------------------------------------------------------
package tva_pkg;

  typedef logic signed [31:0] thrust_t;
  typedef logic signed [15:0] angle_t;

  // internal widths
  localparam int SCW = 34;  // sine / cosine, Q2.30 plus headroom
  localparam int AW  = 35;  // vectoring angle accumulator, Q.30
  localparam int NW  = 43;  // normalized u, v, w
  localparam int VW  = 45;  // vectoring x / y datapath

  localparam logic signed [SCW-1:0] HALF_PI_SC = 34'sd1686629713;
  localparam logic signed [SCW-1:0] PI_SC      = 34'sd3373259426;
  localparam logic signed [SCW-1:0] KINV_SC    = 34'sd652032874;
  localparam logic signed [AW-1:0]  PI_A       = 35'sd3373259426;
  localparam logic signed [61:0]    KINV_W     = 62'sd652032874;

  typedef struct packed {
    logic signed [NW-1:0] u;
    logic signed [NW-1:0] v;
    logic signed [NW-1:0] w;
    logic        [NW-2:0] m;
  } nv_t;

  // atan(2^-i) in Q.30, truncated
  function automatic logic [30:0] atan_q30(input logic [4:0] idx);
    logic [30:0] r;
    case (idx)
      5'd0:  r = 31'h3243F6A8;
      5'd1:  r = 31'h1DAC6705;
      5'd2:  r = 31'h0FADBAFC;
      5'd3:  r = 31'h07F56EA6;
      5'd4:  r = 31'h03FEAB76;
      5'd5:  r = 31'h01FFD55B;
      5'd6:  r = 31'h00FFFAAA;
      5'd7:  r = 31'h007FFF55;
      5'd8:  r = 31'h003FFFEA;
      5'd9:  r = 31'h001FFFFD;
      5'd10: r = 31'h000FFFFF;
      5'd11: r = 31'h0007FFFF;
      5'd12: r = 31'h0003FFFF;
      5'd13: r = 31'h0001FFFF;
      5'd14: r = 31'h0000FFFF;
      5'd15: r = 31'h00007FFF;
      5'd16: r = 31'h00003FFF;
      5'd17: r = 31'h00001FFF;
      5'd18: r = 31'h00000FFF;
      5'd19: r = 31'h000007FF;
      5'd20: r = 31'h000003FF;
      5'd21: r = 31'h000001FF;
      5'd22: r = 31'h000000FF;
      5'd23: r = 31'h0000007F;
      5'd24: r = 31'h0000003F;
      5'd25: r = 31'h0000001F;
      5'd26: r = 31'h0000000F;
      5'd27: r = 31'h00000007;
      5'd28: r = 31'h00000003;
      5'd29: r = 31'h00000001;
      default: r = 31'h0;
    endcase
    return r;
  endfunction

  // Q.30 angle to Q3.13, round half up, saturated
  function automatic angle_t to_q13(input logic signed [AW-1:0] z);
    logic signed [AW:0]    t;
    logic signed [AW-17:0] s;
    angle_t                r;
    t = (AW+1)'(z) + 36'sd65536;
    s = (AW-16)'(t >>> 17);
    if (s > 19'sd32767) begin
      r = 16'sh7FFF;
    end else if (s < -19'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = 16'(s);
    end
    return r;
  endfunction

endpackage

FILE: hdl/tva_in_if.sv
// ----------------------------------------------------------------------------
// tva_in_if
// Input channel: thrust setpoint and current attitude, valid/ready.
// ----------------------------------------------------------------------------
interface tva_in_if;
  import tva_pkg::*;
  logic    valid;
  logic    ready;
  thrust_t thrust_x;
  thrust_t thrust_y;
  thrust_t thrust_z;
  angle_t  roll_now;
  angle_t  pitch_now;
  angle_t  yaw_now;

  modport source(output valid, thrust_x, thrust_y, thrust_z, roll_now, pitch_now,
                 yaw_now, input ready);
  modport sink(input valid, thrust_x, thrust_y, thrust_z, roll_now, pitch_now,
               yaw_now, output ready);
endinterface

FILE: hdl/tva_out_if.sv
// ----------------------------------------------------------------------------
// tva_out_if
// Output channel: roll / pitch command and body thrust, valid/ready.
// ----------------------------------------------------------------------------
interface tva_out_if;
  import tva_pkg::*;
  logic    valid;
  logic    ready;
  angle_t  roll_cmd;
  angle_t  pitch_cmd;
  thrust_t body_thrust;

  modport source(output valid, roll_cmd, pitch_cmd, body_thrust, input ready);
  modport sink(input valid, roll_cmd, pitch_cmd, body_thrust, output ready);
endinterface

FILE: hdl/tva_delay.sv
// ----------------------------------------------------------------------------
// tva_delay
// Enabled shift line that keeps side data aligned with the pipeline.
// ----------------------------------------------------------------------------
module tva_delay #(
  parameter int W = 1,
  parameter int D = 1
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);
  logic [W-1:0] tap [D];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < D; k++) tap[k] <= '0;
    end else if (en) begin
      tap[0] <= d;
      for (int k = 1; k < D; k++) tap[k] <= tap[k-1];
    end
  end

  assign q = tap[D-1];
endmodule

FILE: hdl/tva_sincos.sv
// ----------------------------------------------------------------------------
// tva_sincos
// Pipelined rotation CORDIC: Q3.13 angle in, gain-corrected sine and cosine
// in Q2.30 out, one stage per iteration.
// ----------------------------------------------------------------------------
module tva_sincos #(
  parameter int STAGES = 16
) (
  input  logic                         clk,
  input  logic                         en,
  input  tva_pkg::angle_t              ang,
  output logic signed [tva_pkg::SCW-1:0] s,
  output logic signed [tva_pkg::SCW-1:0] c
);
  import tva_pkg::*;

  logic signed [SCW-1:0] xs [STAGES+1];
  logic signed [SCW-1:0] ys [STAGES+1];
  logic signed [SCW-1:0] zs [STAGES+1];
  logic                  ng [STAGES+1];
  logic signed [SCW-1:0] z0;

  assign z0 = SCW'(signed'({ang, 17'b0}));

  // fold angles beyond +-pi/2 once by pi
  always_ff @(posedge clk) begin
    if (en) begin
      xs[0] <= KINV_SC;
      ys[0] <= '0;
      if (z0 > HALF_PI_SC) begin
        zs[0] <= z0 - PI_SC;
        ng[0] <= 1'b1;
      end else if (z0 < -HALF_PI_SC) begin
        zs[0] <= z0 + PI_SC;
        ng[0] <= 1'b1;
      end else begin
        zs[0] <= z0;
        ng[0] <= 1'b0;
      end
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic signed [SCW-1:0] at;
    assign at = SCW'({1'b0, atan_q30(5'(i))});
    always_ff @(posedge clk) begin
      if (en) begin
        ng[i+1] <= ng[i];
        if (zs[i] >= 0) begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - at;
        end else begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + at;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c <= ng[STAGES] ? -xs[STAGES] : xs[STAGES];
      s <= ng[STAGES] ? -ys[STAGES] : ys[STAGES];
    end
  end
endmodule

FILE: hdl/tva_vec.sv
// ----------------------------------------------------------------------------
// tva_vec
// Pipelined vectoring CORDIC: atan2(y, x) in Q.30 and the scaled magnitude.
// ----------------------------------------------------------------------------
module tva_vec #(
  parameter int STAGES = 16
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [tva_pkg::VW-1:0] x,
  input  logic signed [tva_pkg::VW-1:0] y,
  output logic signed [tva_pkg::AW-1:0] ang,
  output logic signed [tva_pkg::VW-1:0] mag
);
  import tva_pkg::*;

  logic signed [VW-1:0] xs [STAGES+1];
  logic signed [VW-1:0] ys [STAGES+1];
  logic signed [AW-1:0] zs [STAGES+1];

  // left half plane: mirror and preload +-pi
  always_ff @(posedge clk) begin
    if (en) begin
      if (x < 0) begin
        xs[0] <= -x;
        ys[0] <= -y;
        zs[0] <= (y >= 0) ? PI_A : -PI_A;
      end else begin
        xs[0] <= x;
        ys[0] <= y;
        zs[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic signed [AW-1:0] at;
    assign at = AW'({1'b0, atan_q30(5'(i))});
    always_ff @(posedge clk) begin
      if (en) begin
        if (ys[i] >= 0) begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + at;
        end else begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - at;
        end
      end
    end
  end

  assign ang = zs[STAGES];
  assign mag = xs[STAGES];
endmodule

FILE: hdl/thrust_vector_to_attitude.sv
// ----------------------------------------------------------------------------
// thrust_vector_to_attitude
// Thrust setpoint to roll / pitch command and body-axis thrust.
// ----------------------------------------------------------------------------
// Fully pipelined: one item can enter every clock while the output is not
// stalled. The pipeline is built from three CORDIC chains in series
// (sine/cosine, pitch vectoring, roll vectoring), one register per iteration,
// plus the multiply and normalize stages between them. The whole pipeline
// advances together whenever the output register is empty or being taken; a
// stall holds every stage.
module thrust_vector_to_attitude #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic       clk,
  input  logic       rst,
  tva_in_if.sink     thrust_in,
  tva_out_if.source  att_out
);
  import tva_pkg::*;

  localparam int S    = CORDIC_STAGES;
  localparam int L_SC = S + 2;
  localparam int LAT  = 3 * S + 12;

  logic en;
  logic vld_out;

  assign en              = !vld_out || att_out.ready;
  assign thrust_in.ready = en;
  assign att_out.valid   = vld_out;

  tva_delay #(.W(1), .D(LAT)) u_vdl (
    .clk(clk), .rst(rst), .en(en), .d(thrust_in.valid), .q(vld_out)
  );

  // sine / cosine of the three angles
  logic signed [SCW-1:0] sy, cy, sr, cr, sp, cp;

  tva_sincos #(.STAGES(S)) u_yaw (
    .clk(clk), .en(en), .ang(thrust_in.yaw_now), .s(sy), .c(cy)
  );
  tva_sincos #(.STAGES(S)) u_roll (
    .clk(clk), .en(en), .ang(thrust_in.roll_now), .s(sr), .c(cr)
  );
  tva_sincos #(.STAGES(S)) u_pitch (
    .clk(clk), .en(en), .ang(thrust_in.pitch_now), .s(sp), .c(cp)
  );

  logic [95:0] t_dly;
  thrust_t     t_x, t_y, t_z;

  tva_delay #(.W(96), .D(L_SC)) u_tdl (
    .clk(clk), .rst(rst), .en(en),
    .d({thrust_in.thrust_x, thrust_in.thrust_y, thrust_in.thrust_z}), .q(t_dly)
  );
  assign t_x = t_dly[95:64];
  assign t_y = t_dly[63:32];
  assign t_z = t_dly[31:0];

  // P1: first products
  logic signed [65:0]    p_xcy, p_ysy, p_xsy, p_ycy;
  logic signed [67:0]    p_crsp, p_crcp;
  logic signed [SCW-1:0] p1_sr, p1_sy, p1_cy;
  thrust_t               p1_x, p1_y, p1_z;

  always_ff @(posedge clk) begin
    if (en) begin
      p_xcy  <= 66'(t_x) * 66'(cy);
      p_ysy  <= 66'(t_y) * 66'(sy);
      p_xsy  <= 66'(t_x) * 66'(sy);
      p_ycy  <= 66'(t_y) * 66'(cy);
      p_crsp <= 68'(cr) * 68'(sp);
      p_crcp <= 68'(cr) * 68'(cp);
      p1_sr  <= sr;
      p1_sy  <= sy;
      p1_cy  <= cy;
      p1_x   <= t_x;
      p1_y   <= t_y;
      p1_z   <= t_z;
    end
  end

  // P2: yaw-rotated u, v and the attitude terms
  logic signed [66:0]    sum_u, sum_v;
  logic signed [35:0]    u2, v2;
  logic signed [SCW-1:0] crsp2, c2, p2_sr, p2_sy, p2_cy;
  thrust_t               p2_x, p2_y, p2_z;

  assign sum_u = 67'(p_xcy) + 67'(p_ysy);
  assign sum_v = 67'(p_xsy) - 67'(p_ycy);

  always_ff @(posedge clk) begin
    if (en) begin
      u2    <= 36'(sum_u >>> 30);
      v2    <= 36'(sum_v >>> 30);
      crsp2 <= SCW'(p_crsp >>> 30);
      c2    <= SCW'(p_crcp >>> 30);
      p2_sr <= p1_sr;
      p2_sy <= p1_sy;
      p2_cy <= p1_cy;
      p2_x  <= p1_x;
      p2_y  <= p1_y;
      p2_z  <= p1_z;
    end
  end

  // P3: largest magnitude, attitude products
  logic [NW-2:0]         au, av, aw, mx;
  nv_t                   nv3;
  logic                  zero3;
  logic signed [67:0]    q_ccy, q_ssy, q_csy, q_scy;
  logic signed [SCW-1:0] c3;
  thrust_t               p3_x, p3_y, p3_z;

  always_comb begin
    au = (NW-1)'(u2 < 0 ? -NW'(u2) : NW'(u2));
    av = (NW-1)'(v2 < 0 ? -NW'(v2) : NW'(v2));
    aw = (NW-1)'(p2_z < 0 ? -NW'(p2_z) : NW'(p2_z));
    mx = au;
    if (av > mx) mx = av;
    if (aw > mx) mx = aw;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nv3.u <= NW'(u2);
      nv3.v <= NW'(v2);
      nv3.w <= NW'(p2_z);
      nv3.m <= mx;
      zero3 <= (p2_z == '0);
      q_ccy <= 68'(crsp2) * 68'(p2_cy);
      q_ssy <= 68'(p2_sr) * 68'(p2_sy);
      q_csy <= 68'(crsp2) * 68'(p2_sy);
      q_scy <= 68'(p2_sr) * 68'(p2_cy);
      c3    <= c2;
      p3_x  <= p2_x;
      p3_y  <= p2_y;
      p3_z  <= p2_z;
    end
  end

  // shift all three up by s when the largest still fits below 2^41
  function automatic nv_t norm_step(input nv_t n, input int s);
    nv_t r;
    r = n;
    if (n.m < ((NW-1)'(1) << (41 - s))) begin
      r.u = n.u <<< s;
      r.v = n.v <<< s;
      r.w = n.w <<< s;
      r.m = n.m << s;
    end
    return r;
  endfunction

  // P4: body-axis coefficients, normalize by 32 and 16
  logic signed [34:0]    a4, b4;
  logic signed [SCW-1:0] c4;
  nv_t                   nv4;
  logic                  zero4;
  thrust_t               p4_x, p4_y, p4_z;

  always_ff @(posedge clk) begin
    if (en) begin
      a4    <= 35'(q_ccy >>> 30) + 35'(q_ssy >>> 30);
      b4    <= 35'(q_csy >>> 30) - 35'(q_scy >>> 30);
      c4    <= c3;
      nv4   <= norm_step(norm_step(nv3, 32), 16);
      zero4 <= zero3;
      p4_x  <= p3_x;
      p4_y  <= p3_y;
      p4_z  <= p3_z;
    end
  end

  // P5: projection products, normalize by 8 and 4
  logic signed [66:0] r_a, r_b, r_c;
  nv_t                nv5;
  logic               zero5;

  always_ff @(posedge clk) begin
    if (en) begin
      r_a   <= 67'(p4_x) * 67'(a4);
      r_b   <= 67'(p4_y) * 67'(b4);
      r_c   <= 67'(p4_z) * 67'(c4);
      nv5   <= norm_step(norm_step(nv4, 8), 4);
      zero5 <= zero4;
    end
  end

  // P6: body thrust sum and saturation, normalize by 2 and 1
  logic signed [38:0] bt_sum;
  thrust_t            bt6;
  nv_t                nv6;
  logic               zero6;

  assign bt_sum = 39'(r_a >>> 30) + 39'(r_b >>> 30) + 39'(r_c >>> 30);

  always_ff @(posedge clk) begin
    if (en) begin
      if (bt_sum > 39'sd2147483647) begin
        bt6 <= 32'sh7FFFFFFF;
      end else if (bt_sum < -39'sd2147483648) begin
        bt6 <= 32'sh80000000;
      end else begin
        bt6 <= 32'(bt_sum);
      end
      nv6   <= norm_step(norm_step(nv5, 2), 1);
      zero6 <= zero5;
    end
  end

  // pitch = atan2(u, w)
  logic signed [AW-1:0] pz;
  logic signed [VW-1:0] pmag;

  tva_vec #(.STAGES(S)) u_vpitch (
    .clk(clk), .en(en), .x(VW'(nv6.w)), .y(VW'(nv6.u)), .ang(pz), .mag(pmag)
  );

  // hypot gain removal
  logic signed [61:0] hprod;
  angle_t             p13;

  always_ff @(posedge clk) begin
    if (en) begin
      hprod <= 62'(pmag >>> 15) * KINV_W;
      p13   <= to_q13(pz);
    end
  end

  logic [NW-1:0] v_d;
  tva_delay #(.W(NW), .D(S + 2)) u_vdly (
    .clk(clk), .rst(rst), .en(en), .d(nv6.v), .q(v_d)
  );

  // roll = atan2(v, hypot(u, w))
  logic signed [AW-1:0] rz;
  logic signed [VW-1:0] rmag;

  tva_vec #(.STAGES(S)) u_vroll (
    .clk(clk), .en(en), .x(VW'(hprod >>> 15)), .y(VW'(signed'(v_d))),
    .ang(rz), .mag(rmag)
  );

  logic [15:0] p13_d;
  logic [32:0] bz_d;

  tva_delay #(.W(16), .D(S + 1)) u_pdly (
    .clk(clk), .rst(rst), .en(en), .d(p13), .q(p13_d)
  );
  tva_delay #(.W(33), .D(2 * S + 3)) u_bdly (
    .clk(clk), .rst(rst), .en(en), .d({zero6, bt6}), .q(bz_d)
  );

  // output register
  angle_t  roll_o, pitch_o;
  thrust_t bt_o;

  always_ff @(posedge clk) begin
    if (en) begin
      roll_o  <= bz_d[32] ? '0 : to_q13(rz);
      pitch_o <= bz_d[32] ? '0 : angle_t'(p13_d);
      bt_o    <= thrust_t'(bz_d[31:0]);
    end
  end

  assign att_out.roll_cmd    = roll_o;
  assign att_out.pitch_cmd   = pitch_o;
  assign att_out.body_thrust = bt_o;

endmodule
